>>> hw/rtl/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

	// Counter width of the byte count
	localparam int COUNT_WIDTH = 24;

	// Widths of the register and result fields
	localparam int CAP_W   = 24;
	localparam int TOTAL_W = 24;
	localparam int UNIT_W  = 16;
	localparam int BYTE_W  = 8;

	// Compare width: wide enough for counter or capacity plus a short code point
	localparam int SUM_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;
	localparam logic [SUM_W-1:0] COUNT_MAX =
		SUM_W'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam logic [SUM_W-1:0] TOTAL_MAX =
		SUM_W'((64'd1 << TOTAL_W) - 64'd1);

	// Code point, sequence length and byte index widths
	localparam int CP_W  = 21;
	localparam int LEN_W = 3;
	localparam int IDX_W = 2;
	localparam int HIGH_W = 10;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_ONLY = 1'd1;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Surrogate ranges and sequence lengths
	localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
	localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
	localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
	localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;
	localparam logic [LEN_W-1:0]  LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0]  LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0]  LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0]  LEN_4 = 3'd4;

	// Work handed from front to back: up to two code points and a summary
	typedef struct packed {
		logic                a_en;       // lone held high surrogate, 3 bytes
		logic [HIGH_W-1:0]   a_bits;
		logic                b_en;       // current code point
		logic [CP_W-1:0]     b_cp;
		logic [LEN_W-1:0]    b_len;
		logic                sum_en;     // end-of-string summary
		logic                sum_status;
		logic [TOTAL_W-1:0]  sum_total;
	} job_t;

	// Back end position within a job
	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_SUM
	} phase_t;

	// UTF-8 length of a BMP code unit
	function automatic logic [LEN_W-1:0] unit_len(input logic [UNIT_W-1:0] u);
		logic [LEN_W-1:0] n;
		if (u <= 16'h007F) begin
			n = LEN_1;
		end else if (u <= 16'h07FF) begin
			n = LEN_2;
		end else begin
			n = LEN_3;
		end
		return n;
	endfunction

	// Byte idx of the n-byte UTF-8 sequence of cp
	function automatic logic [BYTE_W-1:0] utf8_byte(input logic [CP_W-1:0] cp,
			input logic [LEN_W-1:0] n, input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		b = 8'h00;
		case (n)
			LEN_1: b = cp[7:0];
			LEN_2: begin
				case (idx)
					2'd0:    b = 8'hC0 | {3'b000, cp[10:6]};
					default: b = 8'h80 | {2'b00, cp[5:0]};
				endcase
			end
			LEN_3: begin
				case (idx)
					2'd0:    b = 8'hE0 | {4'b0000, cp[15:12]};
					2'd1:    b = 8'h80 | {2'b00, cp[11:6]};
					default: b = 8'h80 | {2'b00, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0:    b = 8'hF0 | {5'b00000, cp[20:18]};
					2'd1:    b = 8'h80 | {2'b00, cp[17:12]};
					2'd2:    b = 8'h80 | {2'b00, cp[11:6]};
					default: b = 8'h80 | {2'b00, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/u16u8_front.sv
`default_nettype none

module u16u8_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [u16u8_pkg::UNIT_W-1:0]  code_unit,
	input  wire logic                          last_unit,
	input  wire logic [u16u8_pkg::CAP_W-1:0]   capacity,
	input  wire logic                          query_only,
	output u16u8_pkg::job_t                    job,
	output logic                               push
);

	localparam int SW = u16u8_pkg::SUM_W;

	logic [u16u8_pkg::HIGH_W-1:0]      held_bits_q;
	logic                              held_valid_q;
	logic [u16u8_pkg::COUNT_WIDTH-1:0] count_q;
	logic                              ovf_q;

	logic                         is_high, is_low, query;
	logic                         a_pres, b_pair, b_pres, a_adds;
	logic [u16u8_pkg::LEN_W-1:0]  n_b;
	logic [SW-1:0]                cnt_ext, limit, s_a, s_b0, s_b3, s_b, c_a, c_b;
	logic                         emit_a, emit_b, ovf_a, ovf_b;
	logic                         fit_a, fit_b;
	logic [u16u8_pkg::CP_W-1:0]   pair_cp;

	// Classify the unit
	assign is_high = (code_unit >= u16u8_pkg::HIGH_FIRST) && (code_unit <= u16u8_pkg::HIGH_LAST);
	assign is_low  = (code_unit >= u16u8_pkg::LOW_FIRST) && (code_unit <= u16u8_pkg::LOW_LAST);
	assign query   = (capacity == '0) || query_only;

	assign a_pres = held_valid_q && !is_low;
	assign b_pair = held_valid_q && is_low;
	assign b_pres = b_pair || !(is_high && !last_unit);
	assign n_b    = b_pair ? u16u8_pkg::LEN_4 : u16u8_pkg::unit_len(code_unit);

	assign pair_cp = u16u8_pkg::SUPP_BASE + {1'b0, held_bits_q, code_unit[9:0]};

	// Limit is the smaller of capacity and the counter's max
	assign cnt_ext = SW'(count_q);
	assign limit   = (SW'(capacity) < u16u8_pkg::COUNT_MAX) ? SW'(capacity)
	                                                        : u16u8_pkg::COUNT_MAX;

	// Sums for both code points computed side by side
	assign s_a  = cnt_ext + SW'(u16u8_pkg::LEN_3);
	assign s_b0 = cnt_ext + SW'(n_b);
	assign s_b3 = cnt_ext + SW'(n_b + u16u8_pkg::LEN_3);
	assign fit_a = (s_a <= limit);

	// Held lone surrogate
	always_comb begin
		c_a    = cnt_ext;
		ovf_a  = ovf_q;
		emit_a = 1'b0;
		if (a_pres) begin
			if (query) begin
				c_a = (s_a > u16u8_pkg::COUNT_MAX) ? u16u8_pkg::COUNT_MAX : s_a;
			end else if (!ovf_q) begin
				if (fit_a) begin
					c_a    = s_a;
					emit_a = 1'b1;
				end else begin
					ovf_a = 1'b1;
				end
			end
		end
	end

	assign a_adds = a_pres && (query || emit_a);
	assign s_b    = a_adds ? s_b3 : s_b0;
	assign fit_b  = a_adds ? (s_b3 <= limit) : (s_b0 <= limit);

	// Current code point
	always_comb begin
		c_b    = c_a;
		ovf_b  = ovf_a;
		emit_b = 1'b0;
		if (b_pres) begin
			if (query) begin
				c_b = (s_b > u16u8_pkg::COUNT_MAX) ? u16u8_pkg::COUNT_MAX : s_b;
			end else if (!ovf_a) begin
				if (fit_b) begin
					c_b    = s_b;
					emit_b = 1'b1;
				end else begin
					ovf_b = 1'b1;
				end
			end
		end
	end

	// Job for the back end
	always_comb begin
		job.a_en       = emit_a;
		job.a_bits     = held_bits_q;
		job.b_en       = emit_b;
		job.b_cp       = b_pair ? pair_cp : u16u8_pkg::CP_W'(code_unit);
		job.b_len      = n_b;
		job.sum_en     = last_unit;
		job.sum_status = ovf_b;
		if (ovf_b) begin
			job.sum_total = '0;
		end else if (c_b > u16u8_pkg::TOTAL_MAX) begin
			job.sum_total = u16u8_pkg::TOTAL_MAX[u16u8_pkg::TOTAL_W-1:0];
		end else begin
			job.sum_total = c_b[u16u8_pkg::TOTAL_W-1:0];
		end
	end

	assign push = accept && (emit_a || emit_b || last_unit);

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q  <= '0;
			held_valid_q <= 1'b0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
		end else if (accept) begin
			if (last_unit) begin
				held_bits_q  <= '0;
				held_valid_q <= 1'b0;
				count_q      <= '0;
				ovf_q        <= 1'b0;
			end else begin
				held_valid_q <= is_high;
				if (is_high) begin
					held_bits_q <= code_unit[9:0];
				end
				count_q <= c_b[u16u8_pkg::COUNT_WIDTH-1:0];
				ovf_q   <= ovf_b;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_queue.sv
`default_nettype none

module u16u8_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire u16u8_pkg::job_t wr_data,
	input  wire logic  pop,
	output u16u8_pkg::job_t rd_data,
	output logic       full,
	output logic       empty
);

	u16u8_pkg::job_t                 entry_q [u16u8_pkg::QUEUE_DEPTH];
	logic [u16u8_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [u16u8_pkg::QCNT_W-1:0]    count_q;
	logic                            do_push, do_pop;

	assign full    = (count_q == u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_back.sv
`default_nettype none

module u16u8_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire u16u8_pkg::job_t                head,
	input  wire logic                           head_valid,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [u16u8_pkg::BYTE_W-1:0]        out_byte,
	output logic                                byte_valid,
	output logic                                summary_valid,
	output logic                                status,
	output logic [u16u8_pkg::TOTAL_W-1:0]       byte_total,
	output logic                                run_end
);

	u16u8_pkg::phase_t               phase_q, phase_d, cur;
	logic [u16u8_pkg::IDX_W-1:0]     idx_q, idx_d;
	logic [u16u8_pkg::LEN_W-1:0]     cur_len;
	logic                            phase_last, job_last, load;
	logic [u16u8_pkg::CP_W-1:0]      a_cp;

	logic [u16u8_pkg::BYTE_W-1:0]    r_byte;
	logic                            r_bv, r_sv, r_st, r_end;
	logic [u16u8_pkg::TOTAL_W-1:0]   r_total;
	logic                            out_valid_q;

	// Skip parts of the job that carry no bytes
	always_comb begin
		case (phase_q)
			u16u8_pkg::PH_A: cur = head.a_en ? u16u8_pkg::PH_A
			                     : (head.b_en ? u16u8_pkg::PH_B : u16u8_pkg::PH_SUM);
			u16u8_pkg::PH_B: cur = head.b_en ? u16u8_pkg::PH_B : u16u8_pkg::PH_SUM;
			default:         cur = u16u8_pkg::PH_SUM;
		endcase
	end

	always_comb begin
		case (cur)
			u16u8_pkg::PH_A: cur_len = u16u8_pkg::LEN_3;
			u16u8_pkg::PH_B: cur_len = head.b_len;
			default:         cur_len = u16u8_pkg::LEN_1;
		endcase
	end

	assign phase_last = (u16u8_pkg::LEN_W'(idx_q) == cur_len - 1'b1);

	always_comb begin
		case (cur)
			u16u8_pkg::PH_A: job_last = phase_last && !head.b_en && !head.sum_en;
			u16u8_pkg::PH_B: job_last = phase_last && !head.sum_en;
			default:         job_last = 1'b1;
		endcase
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && job_last;

	// Next position within the job
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		if (load) begin
			if (job_last) begin
				phase_d = u16u8_pkg::PH_A;
				idx_d   = '0;
			end else if (phase_last) begin
				phase_d = (cur == u16u8_pkg::PH_A) ? u16u8_pkg::PH_B : u16u8_pkg::PH_SUM;
				idx_d   = '0;
			end else begin
				idx_d = idx_q + 1'b1;
			end
		end
	end

	// Word at the current position
	assign a_cp = {5'b00000, u16u8_pkg::HIGH_FIRST[15:10], head.a_bits};

	always_comb begin
		r_byte  = '0;
		r_bv    = 1'b0;
		r_sv    = 1'b0;
		r_st    = 1'b0;
		r_total = '0;
		r_end   = job_last;
		case (cur)
			u16u8_pkg::PH_A: begin
				r_byte = u16u8_pkg::utf8_byte(a_cp, u16u8_pkg::LEN_3, idx_q);
				r_bv   = 1'b1;
			end
			u16u8_pkg::PH_B: begin
				r_byte = u16u8_pkg::utf8_byte(head.b_cp, head.b_len, idx_q);
				r_bv   = 1'b1;
			end
			default: begin
				r_sv    = 1'b1;
				r_st    = head.sum_status;
				r_total = head.sum_total;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= u16u8_pkg::PH_A;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte      <= r_byte;
			byte_valid    <= r_bv;
			summary_valid <= r_sv;
			status        <= r_st;
			byte_total    <= r_total;
			run_end       <= r_end;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/utf16_to_utf8_transcoder.sv
`default_nettype none

// UTF-16 to UTF-8 transcoder. Code units come in one word per cycle on the in
// channel; the front end pairs surrogates, checks each code point against the
// capacity register (or only counts in query mode) and hands the work to a
// 4-entry job queue. The back end sends one result word per cycle while the
// output is ready: one per UTF-8 byte, then a summary word on the last unit of
// a string, with run_end on the last word caused by each input unit. A unit is
// taken every cycle while the queue has room, also while the back end is still
// sending the bytes of earlier units; sustained throughput is set by the
// byte-serial back end at one output word per cycle. Units that yield no word
// (a held high surrogate, a unit in query mode other than the last of a string)
// are not queued. The first word of a unit passes through the job queue and
// then the output register. Write configuration only while idle.
module utf16_to_utf8_transcoder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration
	input  wire logic                               cfg_we,
	input  wire logic [u16u8_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [u16u8_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [u16u8_pkg::UNIT_W-1:0]       code_unit,
	input  wire logic                               last_unit,
	// Output channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [u16u8_pkg::BYTE_W-1:0]            out_byte,
	output logic                                    byte_valid,
	output logic                                    summary_valid,
	output logic                                    status,
	output logic [u16u8_pkg::TOTAL_W-1:0]           byte_total,
	output logic                                    run_end
);

	logic [u16u8_pkg::CAP_W-1:0] capacity_q;
	logic                        query_only_q;
	logic                        accept, push, pop, full, empty;
	u16u8_pkg::job_t             job, head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= '0;
			query_only_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				u16u8_pkg::REG_CAPACITY:   capacity_q   <= cfg_data[u16u8_pkg::CAP_W-1:0];
				u16u8_pkg::REG_QUERY_ONLY: query_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (code_unit),
		.last_unit  (last_unit),
		.capacity   (capacity_q),
		.query_only (query_only_q),
		.job        (job),
		.push       (push)
	);

	u16u8_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job),
		.pop     (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (!empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.summary_valid (summary_valid),
		.status        (status),
		.byte_total    (byte_total),
		.run_end       (run_end)
	);

endmodule

`default_nettype wire

>>> tb/sv/utf16_to_utf8_transcoder_test.sv
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_test;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_CYCLES  = 120;

	localparam int unsigned CNT_MAX = 32'h00FF_FFFF;
	localparam logic [23:0] CAP_MAX = 24'hFF_FFFF;

	localparam logic [15:0] HI_SURR_MIN = 16'hD800;
	localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_START  = 21'h10000;

	// One UTF-16 code unit as offered on the input channel
	typedef struct packed {
		logic [15:0] unit;
		logic        last;
	} utf16_item_t;

	// One result word of the output channel
	typedef struct packed {
		logic [7:0]  data;
		logic        is_byte;
		logic        is_sum;
		logic        short_buf;
		logic [23:0] total;
		logic        ends_run;
	} utf8_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                  cfg_we = 1'b0;
	logic [u16u8_pkg::CFG_IDX_W-1:0]       cfg_index = u16u8_pkg::REG_CAPACITY;
	logic [u16u8_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = '0;
	logic        last_unit = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        summary_valid;
	logic        status;
	logic [23:0] byte_total;
	logic        run_end;

	utf16_to_utf8_transcoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.code_unit     (code_unit),
		.last_unit     (last_unit),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.summary_valid (summary_valid),
		.status        (status),
		.byte_total    (byte_total),
		.run_end       (run_end)
	);

	// Clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Units waiting for the driver, words waiting for the DUT
	utf16_item_t unit_pending[$];
	utf8_word_t  utf8_expected[$];

	// Transcoder shadow: registers and string state
	logic [23:0] cap_reg = '0;
	logic        query_reg = 1'b0;
	logic [9:0]  held_bits = '0;
	logic        held = 1'b0;
	int unsigned byte_count = 0;
	logic        overflow_seen = 1'b0;

	int unsigned units_queued = 0;
	int unsigned units_accepted = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned bytes_seen = 0;
	int unsigned sums_seen = 0;
	int unsigned short_seen = 0;

	int unsigned snd_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	int unsigned stall_requests = 0;
	int unsigned stall_served = 0;
	int unsigned stall_left = 0;

	logic        in_fire = 1'b0;
	utf16_item_t drv_item;

	function automatic void push_word(input logic [7:0] data, input logic is_byte,
			input logic is_sum, input logic short_buf, input logic [23:0] total);
		utf8_word_t w;
		w.data      = data;
		w.is_byte   = is_byte;
		w.is_sum    = is_sum;
		w.short_buf = short_buf;
		w.total     = total;
		w.ends_run  = 1'b0;
		utf8_expected.push_back(w);
	endfunction

	// Encode one code point: count only in query mode, else bound by capacity
	function automatic void encode_point(input logic [20:0] cp);
		int unsigned n;
		logic [7:0]  seq[4];
		if (cp <= 21'h7F) begin
			n = 1;
		end else if (cp <= 21'h7FF) begin
			n = 2;
		end else if (cp <= 21'hFFFF) begin
			n = 3;
		end else begin
			n = 4;
		end
		if (cap_reg == 0 || query_reg) begin
			byte_count = (byte_count + n > CNT_MAX) ? CNT_MAX : byte_count + n;
			return;
		end
		if (overflow_seen) begin
			return;
		end
		// capacity never exceeds the counter range at this width
		if (byte_count + n > cap_reg) begin
			overflow_seen = 1'b1;
			return;
		end
		case (n)
			1: seq[0] = cp[7:0];
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < n; i++) begin
			push_word(seq[i], 1'b1, 1'b0, 1'b0, '0);
		end
		byte_count += n;
	endfunction

	// Expected words for one accepted code unit
	function automatic void predict_unit(input logic [15:0] unit, input logic last);
		logic       hi;
		logic       lo;
		logic       paired;
		int         base;
		utf8_word_t w;
		hi = unit >= HI_SURR_MIN && unit <= HI_SURR_MAX;
		lo = unit >= LO_SURR_MIN && unit <= LO_SURR_MAX;
		base = utf8_expected.size();
		paired = 1'b0;
		if (held) begin
			held = 1'b0;
			if (lo) begin
				encode_point(SUPP_START + 21'({held_bits, unit[9:0]}));
				paired = 1'b1;
			end else begin
				// lone high surrogate flushed as a 3-byte sequence
				encode_point({5'd0, 6'b110110, held_bits});
			end
		end
		if (!paired) begin
			if (hi && !last) begin
				held_bits = unit[9:0];
				held = 1'b1;
			end else begin
				encode_point({5'd0, unit});
			end
		end
		if (last) begin
			push_word('0, 1'b0, 1'b1, overflow_seen,
				overflow_seen ? 24'd0 : 24'(byte_count));
			held_bits = '0;
			held = 1'b0;
			byte_count = 0;
			overflow_seen = 1'b0;
		end
		if (utf8_expected.size() > base) begin
			w = utf8_expected.pop_back();
			w.ends_run = 1'b1;
			utf8_expected.push_back(w);
		end
	endfunction

	// Input acceptance, prediction and output check at the rising edge
	always @(posedge clk) begin
		utf8_word_t w;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end else begin
			in_fire = arst_n && in_valid && in_ready;
			if (in_fire) begin
				predict_unit(code_unit, last_unit);
				units_accepted++;
			end
			if (arst_n && out_valid && out_ready) begin
				if (utf8_expected.size() == 0) begin
					$error("word with nothing expected: out_byte %0h summary_valid %0b",
						out_byte, summary_valid);
					fail_count++;
				end else begin
					w = utf8_expected.pop_front();
					if (out_byte !== w.data) begin
						$error("out_byte: expected %0h, got %0h", w.data, out_byte);
						fail_count++;
					end
					if (byte_valid !== w.is_byte) begin
						$error("byte_valid: expected %0b, got %0b", w.is_byte, byte_valid);
						fail_count++;
					end
					if (summary_valid !== w.is_sum) begin
						$error("summary_valid: expected %0b, got %0b", w.is_sum, summary_valid);
						fail_count++;
					end
					if (status !== w.short_buf) begin
						$error("status: expected %0b, got %0b", w.short_buf, status);
						fail_count++;
					end
					if (byte_total !== w.total) begin
						$error("byte_total: expected %0d, got %0d", w.total, byte_total);
						fail_count++;
					end
					if (run_end !== w.ends_run) begin
						$error("run_end: expected %0b, got %0b", w.ends_run, run_end);
						fail_count++;
					end
					if (w.is_byte) begin
						bytes_seen++;
					end
					if (w.is_sum) begin
						sums_seen++;
						if (w.short_buf) begin
							short_seen++;
						end
					end
				end
			end
		end
	end

	// Sender: offer the next unit at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (unit_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				drv_item = unit_pending.pop_front();
				code_unit <= drv_item.unit;
				last_unit <= drv_item.last;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus long hold-offs on request
	always @(negedge clk) begin
		if (stall_served != stall_requests) begin
			stall_served++;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	function automatic void queue_unit(input logic [15:0] unit, input logic last);
		utf16_item_t it;
		it.unit = unit;
		it.last = last;
		unit_pending.push_back(it);
		units_queued++;
	endfunction

	// One string: mostly well-formed text, sometimes raw units and stray surrogates
	function automatic int queue_string(input int unsigned len, input logic tidy);
		logic [15:0] units[$];
		int unsigned r;
		while (units.size() < len) begin
			r = $urandom_range(99);
			if (tidy) begin
				if (r < 35) begin
					units.push_back(16'($urandom_range(16'h0000, 16'h007F)));
				end else if (r < 50) begin
					units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
				end else if (r < 61) begin
					units.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
				end else if (r < 72) begin
					units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
				end else begin
					units.push_back(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
					units.push_back(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
				end
			end else begin
				if (r < 40) begin
					units.push_back(16'($urandom));
				end else if (r < 70) begin
					units.push_back(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
				end else begin
					units.push_back(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
				end
			end
		end
		foreach (units[i]) begin
			queue_unit(units[i], i == units.size() - 1);
		end
		return units.size();
	endfunction

	function automatic void queue_random(input int unsigned count);
		int unsigned added;
		added = 0;
		while (added < count) begin
			added += queue_string($urandom_range(1, 10), $urandom_range(99) < 75);
		end
	endfunction

	// Register write: one cycle of write enable at the falling edge
	task automatic write_reg(input logic [u16u8_pkg::CFG_IDX_W-1:0] idx,
			input logic [u16u8_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input logic [23:0] cap, input logic query);
		write_reg(u16u8_pkg::REG_CAPACITY, cap);
		write_reg(u16u8_pkg::REG_QUERY_ONLY, {23'd0, query});
		cap_reg   = cap;
		query_reg = query;
	endtask

	// Wait until every unit is taken and every word has come, then let it settle
	task automatic wait_idle();
		while (units_accepted != units_queued || utf8_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sender idles more rarely than the receiver
		snd_idle_pct = 35;
		rcv_idle_pct = 54;

		// Write mode, full capacity: length boundaries and surrogate handling
		program_regs(CAP_MAX, 1'b0);
		queue_unit(16'h0000, 1'b0);
		queue_unit(16'h007F, 1'b0);
		queue_unit(16'h0080, 1'b0);
		queue_unit(16'h07FF, 1'b0);
		queue_unit(16'h0800, 1'b0);
		queue_unit(16'hFFFF, 1'b0);
		queue_unit(16'hD800, 1'b0);   // lowest pair
		queue_unit(16'hDC00, 1'b0);
		queue_unit(16'hDBFF, 1'b0);   // highest pair
		queue_unit(16'hDFFF, 1'b0);
		queue_unit(16'hDC00, 1'b0);   // lone low surrogate
		queue_unit(16'hD83D, 1'b0);   // held high, then a plain unit
		queue_unit(16'h0041, 1'b0);
		queue_unit(16'hDBFF, 1'b0);   // high, high, low
		queue_unit(16'hD800, 1'b0);
		queue_unit(16'hDFFF, 1'b0);
		queue_unit(16'hD801, 1'b1);   // high surrogate as last unit
		queue_random(40);
		wait_idle();

		// Query mode by zero capacity, then by the query flag
		program_regs(24'd0, 1'b0);
		queue_random(40);
		wait_idle();
		program_regs(CAP_MAX, 1'b1);
		queue_random(40);
		wait_idle();

		// Receiver idles more rarely than the sender
		snd_idle_pct = 54;
		rcv_idle_pct = 35;

		// Small buffer: overflow on the last unit of a string, with a long receiver hold-off
		program_regs(24'd7, 1'b0);
		stall_requests++;
		queue_unit(16'h0041, 1'b0);
		queue_unit(16'hD83D, 1'b0);
		queue_unit(16'hDE00, 1'b0);
		queue_unit(16'h20AC, 1'b1);
		queue_random(50);
		wait_idle();

		program_regs(24'd1, 1'b0);
		queue_random(30);
		wait_idle();

		// Sender pauses mid-string with a high surrogate held
		program_regs(24'($urandom_range(2, 40)), 1'b0);
		queue_random(25);
		queue_unit(16'h0041, 1'b0);
		queue_unit(16'hD83D, 1'b0);
		wait_idle();
		queue_unit(16'hDE00, 1'b1);
		queue_random(25);
		wait_idle();

		// No idling on either side
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		program_regs(CAP_MAX, 1'b0);
		queue_random(40);

		// Mode switched while a surrogate is held: the pair is only counted
		queue_unit(16'h0041, 1'b0);
		queue_unit(16'hD83D, 1'b0);
		wait_idle();
		program_regs(CAP_MAX, 1'b1);
		queue_unit(16'hDE00, 1'b1);
		wait_idle();

		program_regs(24'd3, 1'b0);
		queue_random(40);
		wait_idle();

		$display("Fed %0d code units; checked %0d UTF-8 bytes and %0d string summaries",
			units_accepted, bytes_seen, sums_seen);
		$display("%0d strings ended short of buffer; %0d mismatches", short_seen, fail_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
